>>> hdl/ptwa_pkg.sv
// shared types, codes and constants of the peer table with aging
package ptwa_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam logic [15:0] ExpiryReset = 16'd70;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpSweep = 1'b1;

  localparam logic [1:0] FamIpv4 = 2'd0;
  localparam logic [1:0] FamIpv6 = 2'd1;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_SWEPT     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_INSERT,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        fam;
    logic [15:0] port;
    logic [15:0] state;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    scan;
    logic    insert;
    logic    result_load;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic is_sweep;
    logic full;
    logic fam_bad;
    logic match;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/ptwa_ctrl.sv
// sequencer for capture, table walk, insert and result hand-off
module ptwa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ptwa_pkg::dp_stat_t stat_i,
  output ptwa_pkg::cmd_t    cmd_o
);

  ptwa_pkg::ctrl_state_e state_q, state_d;
  ptwa_pkg::status_e     code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptwa_pkg::S_IDLE;
      code_q  <= ptwa_pkg::ST_REFRESHED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    code_d             = code_q;
    in_ready_o         = 1'b0;
    cmd_o.capture      = 1'b0;
    cmd_o.scan         = 1'b0;
    cmd_o.insert       = 1'b0;
    cmd_o.result_load  = 1'b0;
    cmd_o.code         = code_q;
    case (state_q)
      ptwa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ptwa_pkg::S_CHECK;
        end
      end
      ptwa_pkg::S_CHECK: begin
        if (stat_i.is_sweep) begin
          state_d = ptwa_pkg::S_SCAN;
        end else if (stat_i.full) begin
          code_d  = ptwa_pkg::ST_FULL;
          state_d = ptwa_pkg::S_DONE;
        end else if (stat_i.fam_bad) begin
          code_d  = ptwa_pkg::ST_UNKNOWN;
          state_d = ptwa_pkg::S_DONE;
        end else begin
          state_d = ptwa_pkg::S_SCAN;
        end
      end
      ptwa_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.match) begin
          code_d  = ptwa_pkg::ST_REFRESHED;
          state_d = ptwa_pkg::S_DONE;
        end else if (stat_i.scan_done) begin
          if (stat_i.is_sweep) begin
            code_d  = ptwa_pkg::ST_SWEPT;
            state_d = ptwa_pkg::S_DONE;
          end else begin
            state_d = ptwa_pkg::S_INSERT;
          end
        end
      end
      ptwa_pkg::S_INSERT: begin
        cmd_o.insert = 1'b1;
        code_d       = ptwa_pkg::ST_INSERTED;
        state_d      = ptwa_pkg::S_DONE;
      end
      ptwa_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = ptwa_pkg::S_IDLE;
        end
      end
      default: state_d = ptwa_pkg::S_IDLE;
    endcase
  end

endmodule

>>> hdl/ptwa_datapath.sv
// entry memory, item registers, walk counters, compare logic and result register
module ptwa_datapath #(
  parameter int unsigned TABLE_ENTRIES = ptwa_pkg::TableEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               operation_i,
  input  logic [1:0]         family_i,
  input  logic [63:0]        address_high_i,
  input  logic [63:0]        address_low_i,
  input  logic [15:0]        port_i,
  input  logic signed [15:0] entry_state_i,
  input  logic [31:0]        timestamp_i,
  input  ptwa_pkg::cmd_t     cmd_i,
  output ptwa_pkg::dp_stat_t stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic [3:0]         entry_index_o,
  output logic [4:0]         entry_count_o,
  output logic [4:0]         removed_count_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

  ptwa_pkg::entry_t mem [TABLE_ENTRIES];
  ptwa_pkg::entry_t rdata_q;

  logic [15:0]   expiry_q;
  logic          op_q;
  logic [1:0]    fam_q;
  logic [63:0]   ahi_q, alo_q;
  logic [15:0]   port_q, st_q;
  logic [31:0]   now_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [CW-1:0] removed_q, removed_d;
  logic          eval_vld_q, eval_vld_d;
  logic [IW-1:0] eval_idx_q;
  logic [IW-1:0] res_idx_q, res_idx_d;
  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [IW-1:0] out_idx_q;
  logic [CW-1:0] out_count_q;
  logic [CW-1:0] out_removed_q;

  logic             issue, hit, drop, eval_on;
  logic [31:0]      age;
  logic             we;
  logic [IW-1:0]    waddr;
  ptwa_pkg::entry_t wdata;

  assign issue   = cmd_i.scan && (rd_ptr_q != count_q);
  assign eval_on = cmd_i.scan && eval_vld_q;
  assign hit     = (rdata_q.fam == fam_q[0]) && (rdata_q.addr_hi == ahi_q) &&
                   (rdata_q.addr_lo == alo_q);
  assign age     = (now_q >= rdata_q.seen) ? (now_q - rdata_q.seen) : 32'd0;
  assign drop    = (rdata_q.state != 16'd0) && (age >= {16'd0, expiry_q});

  assign stat_o.is_sweep  = (op_q == ptwa_pkg::OpSweep);
  assign stat_o.full      = (count_q == Full);
  assign stat_o.fam_bad   = (fam_q != ptwa_pkg::FamIpv4) && (fam_q != ptwa_pkg::FamIpv6);
  assign stat_o.match     = eval_on && (op_q == ptwa_pkg::OpAdd) && hit;
  assign stat_o.scan_done = (rd_ptr_q == count_q) && !eval_vld_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    kept_d     = kept_q;
    removed_d  = removed_q;
    eval_vld_d = issue;
    res_idx_d  = res_idx_q;
    we         = 1'b0;
    waddr      = eval_idx_q;
    wdata      = rdata_q;
    if (cmd_i.capture) begin
      rd_ptr_d  = '0;
      kept_d    = '0;
      removed_d = '0;
      res_idx_d = '0;
    end
    if (issue) begin
      rd_ptr_d = rd_ptr_q + CW'(1);
    end
    if (eval_on && (op_q == ptwa_pkg::OpAdd) && hit) begin
      we         = 1'b1;
      wdata.seen = now_q;
      res_idx_d  = eval_idx_q;
    end
    if (eval_on && (op_q == ptwa_pkg::OpSweep)) begin
      if (drop) begin
        removed_d = removed_q + CW'(1);
      end else begin
        we     = 1'b1;
        waddr  = kept_q[IW-1:0];
        kept_d = kept_q + CW'(1);
      end
    end
    if (cmd_i.scan && stat_o.scan_done && (op_q == ptwa_pkg::OpSweep)) begin
      count_d = kept_q;
    end
    if (cmd_i.insert) begin
      we            = 1'b1;
      waddr         = count_q[IW-1:0];
      wdata.addr_hi = ahi_q;
      wdata.addr_lo = alo_q;
      wdata.fam     = fam_q[0];
      wdata.port    = port_q;
      wdata.state   = st_q;
      wdata.seen    = now_q;
      res_idx_d     = count_q[IW-1:0];
      count_d       = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem[rd_ptr_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q    <= ptwa_pkg::ExpiryReset;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      eval_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expiry_q <= cfg_wdata_i;
      end
      count_q    <= count_d;
      rd_ptr_q   <= rd_ptr_d;
      eval_vld_q <= eval_vld_d;
      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kept_q     <= kept_d;
    removed_q  <= removed_d;
    res_idx_q  <= res_idx_d;
    eval_idx_q <= rd_ptr_q[IW-1:0];
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      fam_q  <= family_i;
      ahi_q  <= (family_i == ptwa_pkg::FamIpv4) ? 64'd0 : address_high_i;
      alo_q  <= (family_i == ptwa_pkg::FamIpv4) ? {32'd0, address_low_i[31:0]}
                                                : address_low_i;
      port_q <= port_i;
      st_q   <= entry_state_i;
      now_q  <= timestamp_i;
    end
    if (cmd_i.result_load) begin
      out_status_q  <= cmd_i.code;
      out_idx_q     <= res_idx_q;
      out_count_q   <= count_q;
      out_removed_q <= removed_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign entry_index_o   = 4'(out_idx_q);
  assign entry_count_o   = 5'(out_count_q);
  assign removed_count_o = 5'(out_removed_q);

endmodule

>>> hdl/peer_table_with_aging.sv
// top level of the peer address table with aging
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid_i / in_ready_o, item fields | in
//  result  | out_valid_o / out_ready_i, fields    | out
//  config  | cfg_we_i, cfg_wdata_i (expiry)       | in
//
// an insert walks all count entries before it writes the new one at slot count,
// a refresh stops the walk at the matching slot, a full-table or unknown-family add
// skips the walk, a sweep walks all entries; count is the number of valid entries
// the walk reads one entry per cycle through the single read port of the entry memory
// reset empties the table and sets expiry to 70 seconds; no clearing pass
// a stalled result holds in the output register; the next beat is accepted meanwhile
module peer_table_with_aging #(
  parameter int unsigned TABLE_ENTRIES = ptwa_pkg::TableEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [1:0]         family_i,
  input  logic [63:0]        address_high_i,
  input  logic [63:0]        address_low_i,
  input  logic [15:0]        port_i,
  input  logic signed [15:0] entry_state_i,
  input  logic [31:0]        timestamp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [3:0]         entry_index_o,
  output logic [4:0]         entry_count_o,
  output logic [4:0]         removed_count_o
);

  ptwa_pkg::cmd_t     cmd;
  ptwa_pkg::dp_stat_t stat;

  ptwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptwa_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .family_i        (family_i),
    .address_high_i  (address_high_i),
    .address_low_i   (address_low_i),
    .port_i          (port_i),
    .entry_state_i   (entry_state_i),
    .timestamp_i     (timestamp_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .entry_index_o   (entry_index_o),
    .entry_count_o   (entry_count_o),
    .removed_count_o (removed_count_o)
  );

endmodule

>>> hdl/ptwa_checker.sv
// port-level checks of the peer table, bound to the top level
module ptwa_props #(
  parameter int unsigned TABLE_ENTRIES = ptwa_pkg::TableEntriesDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] status_i,
  input logic [3:0] entry_index_i,
  input logic [4:0] entry_count_i,
  input logic [4:0] removed_count_i
);

  localparam logic [4:0] FullCount = 5'(TABLE_ENTRIES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(entry_count_i))
    else $error("result beat changed while stalled");

  a_add_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ptwa_pkg::ST_SWEPT) |->
    (removed_count_i == 5'd0))
    else $error("add beat reports removed entries");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ptwa_pkg::ST_FULL) |-> (entry_count_i == FullCount))
    else $error("table full reported with free slots");

  a_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((status_i == ptwa_pkg::ST_FULL) || (status_i == ptwa_pkg::ST_UNKNOWN) ||
    (status_i == ptwa_pkg::ST_SWEPT)) |-> (entry_index_i == 4'd0))
    else $error("index reported without refresh or insert");

endmodule

bind peer_table_with_aging ptwa_props #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_ptwa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_i        (status_o),
  .entry_index_i   (entry_index_o),
  .entry_count_i   (entry_count_o),
  .removed_count_i (removed_count_o)
);

>>> bench/ptwa_checker.sv
// checker for the peer table: watches both channels, predicts each result and compares
module ptwa_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               operation_i,
  input  logic [1:0]         family_i,
  input  logic [63:0]        address_high_i,
  input  logic [63:0]        address_low_i,
  input  logic [15:0]        port_i,
  input  logic signed [15:0] entry_state_i,
  input  logic [31:0]        timestamp_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic [3:0]         entry_index_i,
  input  logic [4:0]         entry_count_i,
  input  logic [4:0]         removed_count_i,
  output int                 fail_count_o,
  output int                 waiting_o,
  output int                 beats_o,
  output int                 refreshes_o,
  output int                 full_drops_o,
  output int                 aged_out_o
);

  localparam int Slots = 16;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        fam;
    logic [15:0] port;
    logic [15:0] word;
    logic [31:0] seen;
  } peer_t;

  typedef struct packed {
    ptwa_pkg::status_e status;
    logic [3:0]        index;
    logic [4:0]        count;
    logic [4:0]        removed;
  } reply_t;

  peer_t       peers_q [Slots];
  int          live = 0;
  logic [15:0] expiry = ptwa_pkg::ExpiryReset;
  reply_t      replies_q [$];
  reply_t      want;
  int          fails = 0;
  int          beats = 0;
  int          refreshes = 0;
  int          full_drops = 0;
  int          aged_out = 0;
  int          waiting = 0;

  assign fail_count_o = fails;
  assign waiting_o    = waiting;
  assign beats_o      = beats;
  assign refreshes_o  = refreshes;
  assign full_drops_o = full_drops;
  assign aged_out_o   = aged_out;

  task automatic report(input string msg);
    $display("ptwa_checker: %s", msg);
    fails++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val) begin
      report($sformatf("beat %0d: %s is %0d, expected %0d", beats, name, got, exp_val));
    end
  endtask

  function automatic reply_t apply_item(input logic op, input logic [1:0] fam,
                                        input logic [63:0] hi, input logic [63:0] lo,
                                        input logic [15:0] port, input logic [15:0] word,
                                        input logic [31:0] now);
    reply_t      r;
    int          kept;
    int          gone;
    logic [31:0] age;
    r = '{status: ptwa_pkg::ST_SWEPT, index: '0, count: '0, removed: '0};
    if (op == ptwa_pkg::OpSweep) begin
      kept = 0;
      gone = 0;
      for (int k = 0; k < live; k++) begin
        age = (now >= peers_q[k].seen) ? now - peers_q[k].seen : 32'd0;
        if (peers_q[k].word != 16'd0 && age >= 32'(expiry)) begin
          gone++;
        end else begin
          peers_q[kept] = peers_q[k];
          kept++;
        end
      end
      live = kept;
      aged_out += gone;
      r.count = 5'(live);
      r.removed = 5'(gone);
      return r;
    end
    r.count = 5'(live);
    if (live >= Slots) begin
      r.status = ptwa_pkg::ST_FULL;
      full_drops++;
      return r;
    end
    if (fam != ptwa_pkg::FamIpv4 && fam != ptwa_pkg::FamIpv6) begin
      r.status = ptwa_pkg::ST_UNKNOWN;
      return r;
    end
    // ipv4 keeps only the low word of the address
    if (fam == ptwa_pkg::FamIpv4) begin
      hi = '0;
      lo = {32'd0, lo[31:0]};
    end
    for (int k = 0; k < live; k++) begin
      if (peers_q[k].fam == fam[0] && peers_q[k].hi == hi && peers_q[k].lo == lo) begin
        peers_q[k].seen = now;
        r.status = ptwa_pkg::ST_REFRESHED;
        r.index = 4'(k);
        refreshes++;
        return r;
      end
    end
    peers_q[live] = '{hi: hi, lo: lo, fam: fam[0], port: port, word: word, seen: now};
    r.status = ptwa_pkg::ST_INSERTED;
    r.index = 4'(live);
    live++;
    r.count = 5'(live);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live = 0;
      expiry = ptwa_pkg::ExpiryReset;
      replies_q.delete();
      waiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_q.size() == 0) begin
          report($sformatf("result beat with nothing expected, status %0d", status_i));
        end else begin
          want = replies_q.pop_front();
          check_field("status", int'(status_i), int'(want.status));
          check_field("entry_index", int'(entry_index_i), int'(want.index));
          check_field("entry_count", int'(entry_count_i), int'(want.count));
          check_field("removed_count", int'(removed_count_i), int'(want.removed));
          beats++;
        end
      end
      if (cfg_we_i) begin
        expiry = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        replies_q.push_back(apply_item(operation_i, family_i, address_high_i, address_low_i,
                                       port_i, entry_state_i, timestamp_i));
      end
      waiting = replies_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench top: stimulus, flow control and verdict for the peer table with aging
module tb_top;

  localparam logic [1:0] FamOther    = 2'd2;
  localparam logic [1:0] FamReserved = 2'd3;
  localparam int PoolSize   = 24;
  localparam int Phases     = 5;
  localparam int PhaseItems = 160;
  localparam int DrainWait  = 24;
  localparam int HoldCycles = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = 1'b0;
  logic [1:0]         family = '0;
  logic [63:0]        addr_hi = '0;
  logic [63:0]        addr_lo = '0;
  logic [15:0]        port = '0;
  logic signed [15:0] entry_state = '0;
  logic [31:0]        stamp = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic [3:0]         entry_index;
  logic [4:0]         entry_count;
  logic [4:0]         removed_count;

  int fails;
  int waiting;
  int beats;
  int refreshes;
  int full_drops;
  int aged_out;

  logic [63:0] pool_hi [PoolSize];
  logic [63:0] pool_lo [PoolSize];
  logic [1:0]  pool_fam [PoolSize];
  logic [31:0] clock_now = '0;
  int          expiry_now = 70;
  int          settings = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  peer_table_with_aging DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .family_i       (family),
    .address_high_i (addr_hi),
    .address_low_i  (addr_lo),
    .port_i         (port),
    .entry_state_i  (entry_state),
    .timestamp_i    (stamp),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .entry_index_o  (entry_index),
    .entry_count_o  (entry_count),
    .removed_count_o(removed_count)
  );

  ptwa_checker peer_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .operation_i    (operation),
    .family_i       (family),
    .address_high_i (addr_hi),
    .address_low_i  (addr_lo),
    .port_i         (port),
    .entry_state_i  (entry_state),
    .timestamp_i    (stamp),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .entry_index_i  (entry_index),
    .entry_count_i  (entry_count),
    .removed_count_i(removed_count),
    .fail_count_o   (fails),
    .waiting_o      (waiting),
    .beats_o        (beats),
    .refreshes_o    (refreshes),
    .full_drops_o   (full_drops),
    .aged_out_o     (aged_out)
  );

  task automatic offer(input logic op, input logic [1:0] fam, input logic [63:0] hi,
                       input logic [63:0] lo, input logic [15:0] prt, input logic [15:0] st,
                       input logic [31:0] ts);
    in_valid    <= 1'b1;
    operation   <= op;
    family      <= fam;
    addr_hi     <= hi;
    addr_lo     <= lo;
    port        <= prt;
    entry_state <= st;
    stamp       <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_expiry(input logic [15:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    expiry_now = int'(value);
    settings++;
  endtask

  task automatic random_item();
    int          roll;
    int          pick;
    int          span;
    logic [31:0] ts;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] st;
    logic [1:0]  fam;
    span = expiry_now / 6 + 3;
    clock_now += 32'($urandom_range(0, span));
    ts = clock_now;
    roll = $urandom_range(9);
    if (roll == 0) ts = clock_now - 32'($urandom_range(0, span * 4));
    else if (roll == 1) ts = clock_now + 32'($urandom_range(1, span * 2));
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    st = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 12) begin
      if (roll < 2) ts = $urandom;
      offer(ptwa_pkg::OpSweep, 2'($urandom), hi, lo, 16'($urandom), st, ts);
    end else if (roll < 17) begin
      fam = ($urandom_range(1) == 0) ? FamOther : FamReserved;
      offer(ptwa_pkg::OpAdd, fam, hi, lo, 16'($urandom), st, ts);
    end else if (roll < 21) begin
      fam = ($urandom_range(1) == 0) ? ptwa_pkg::FamIpv4 : ptwa_pkg::FamIpv6;
      offer(ptwa_pkg::OpAdd, fam, hi, lo, 16'($urandom), st, ts);
    end else begin
      // only a few pool addresses may ever be pinned, so the table keeps draining
      pick = $urandom_range(PoolSize - 1);
      fam = pool_fam[pick];
      if (fam == ptwa_pkg::FamIpv4) begin
        lo = {lo[63:32], pool_lo[pick][31:0]};
      end else begin
        hi = pool_hi[pick];
        lo = pool_lo[pick];
      end
      if (pick < 4 && $urandom_range(1) == 0) st = '0;
      else st = 16'($urandom_range(1, 65535));
      offer(ptwa_pkg::OpAdd, fam, hi, lo, 16'($urandom), st, ts);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: timed out with %0d results outstanding", waiting);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    logic [15:0] expiry_plan [Phases];
    expiry_plan[0] = 16'd0;
    expiry_plan[1] = 16'd1;
    expiry_plan[2] = 16'd65535;
    expiry_plan[3] = 16'($urandom_range(2, 65535));
    expiry_plan[4] = 16'($urandom_range(20, 300));

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty sweep, ipv4 upper bits ignored, family kept apart in the match
    offer(ptwa_pkg::OpSweep, ptwa_pkg::FamIpv4, '0, '0, '0, '0, 32'd0);
    offer(ptwa_pkg::OpAdd, ptwa_pkg::FamIpv4, '1, '1, 16'h0000, 16'h7fff, 32'd0);
    offer(ptwa_pkg::OpAdd, ptwa_pkg::FamIpv4, 64'h0123_4567_89ab_cdef,
          64'ha5a5_a5a5_ffff_ffff, 16'hffff, 16'h8000, 32'd100);
    offer(ptwa_pkg::OpAdd, ptwa_pkg::FamIpv6, '0, 64'h0000_0000_ffff_ffff, 16'h1234,
          16'h0001, 32'd150);
    offer(ptwa_pkg::OpAdd, ptwa_pkg::FamIpv6, '1, '1, 16'hffff, 16'h8000, 32'hffff_ffff);
    offer(ptwa_pkg::OpAdd, FamOther, '1, '1, 16'h0001, 16'h0001, 32'd160);
    offer(ptwa_pkg::OpAdd, FamReserved, '0, '0, 16'h0002, 16'h0002, 32'd160);
    offer(ptwa_pkg::OpAdd, ptwa_pkg::FamIpv4, '0, 64'd7, 16'd53, 16'h0000, 32'd5);
    // one second short of expiry, then exactly at it
    offer(ptwa_pkg::OpSweep, ptwa_pkg::FamIpv4, '0, '0, '0, '0, 32'd169);
    offer(ptwa_pkg::OpSweep, ptwa_pkg::FamIpv6, '1, '1, '1, '1, 32'd170);
    for (int k = 0; k < 13; k++) begin
      offer(ptwa_pkg::OpAdd, ptwa_pkg::FamIpv6, 64'hfeed_0000_0000_0000, 64'(k), 16'(k),
            16'(k + 1), 32'(1000 + k));
    end
    offer(ptwa_pkg::OpAdd, ptwa_pkg::FamIpv4, '0, 64'd99, 16'd1, 16'd1, 32'd2000);
    offer(ptwa_pkg::OpAdd, FamOther, '0, 64'd99, 16'd1, 16'd1, 32'd2000);
    offer(ptwa_pkg::OpSweep, ptwa_pkg::FamIpv4, '0, '0, '0, '0, 32'hffff_ffff);

    for (int k = 0; k < PoolSize; k++) begin
      pool_fam[k] = ($urandom_range(1) == 0) ? ptwa_pkg::FamIpv4 : ptwa_pkg::FamIpv6;
      pool_hi[k]  = {$urandom, $urandom};
      pool_lo[k]  = {$urandom, $urandom};
    end
    clock_now = 32'd10_000;

    for (int p = 0; p < Phases; p++) begin
      set_expiry(expiry_plan[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 1 && n == 40) hold_req = 1'b1;
        calm = (p == 2 && n < 120);
        random_item();
      end
    end
    calm = 1'b0;
    settle();

    $display("tb_top: %0d result beats checked across %0d expiry settings",
             beats, settings);
    $display("tb_top: %0d refreshes, %0d full-table drops, %0d entries aged out",
             refreshes, full_drops, aged_out);
    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> peer_table_with_aging.f
hdl/ptwa_pkg.sv
hdl/ptwa_ctrl.sv
hdl/ptwa_datapath.sv
hdl/peer_table_with_aging.sv
hdl/ptwa_checker.sv
bench/ptwa_checker.sv
bench/tb_top.sv
